>>> src/gdrm_pkg.sv
// Package: shared constants, command codes and types for the delta-R matcher.
`timescale 1ns / 1ps
package gdrm_pkg;
   localparam int MAX_JETS    = 8;
   localparam int MAX_PARTONS = 16;
   localparam int COORD_BITS  = 16;
   localparam int JIDX_BITS   = 3;
   localparam int PIDX_BITS   = 4;
   localparam int DIST_BITS   = 31;
   localparam int DPHI_BITS   = 16;
   localparam int DETA_BITS   = 17;

   localparam logic [DPHI_BITS-1:0] PI_Q     = 16'd12868;
   localparam logic [DPHI_BITS-1:0] TWO_PI_Q = 16'd25736;
   localparam logic [7:0] QUARK_ID_LIMIT = 8'd7;
   localparam logic [7:0] GLUON_ID       = 8'd21;

   localparam logic [1:0] CMD_LOAD_JET    = 2'd0;
   localparam logic [1:0] CMD_LOAD_PARTON = 2'd1;
   localparam logic [1:0] CMD_RUN         = 2'd2;

   localparam logic [1:0] CSR_MAX_DR  = 2'd0;
   localparam logic [1:0] CSR_MIN_PT  = 2'd1;
   localparam logic [1:0] CSR_CLASS   = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]   eta;
      logic signed [COORD_BITS-2:0]   phi;
   } coord_type;

   // Pair control from the sequencer to the distance pipe.
   typedef struct packed {
      logic                 valid;
      logic [JIDX_BITS-1:0] jet;
      logic [PIDX_BITS-1:0] parton;
      logic                 sweep_end;
   } pair_type;
endpackage

>>> src/gdrm_store.sv
// Coordinate memories for jets and partons, with registered synchronous read.
`timescale 1ns / 1ps
module gdrm_store
   import gdrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 jet_we,
   input  logic [JIDX_BITS-1:0] jet_waddr,
   input  logic                 parton_we,
   input  logic [PIDX_BITS-1:0] parton_waddr,
   input  coord_type            wdata,
   input  logic [JIDX_BITS-1:0] jet_raddr,
   input  logic [PIDX_BITS-1:0] parton_raddr,
   output coord_type            jet_rdata,
   output coord_type            parton_rdata
);
   coord_type jet_mem [MAX_JETS];
   coord_type parton_mem [MAX_PARTONS];

   // Write on load, read every cycle
   always_ff @(posedge clock) begin
      if (jet_we) begin
         jet_mem[jet_waddr] <= wdata;
      end
      jet_rdata <= jet_mem[jet_raddr];
   end

   always_ff @(posedge clock) begin
      if (parton_we) begin
         parton_mem[parton_waddr] <= wdata;
      end
      parton_rdata <= parton_mem[parton_raddr];
   end
endmodule

>>> src/gdrm_dist.sv
// Distance pipe: differences, phi wrap, squares, sum and running minimum.
`timescale 1ns / 1ps
module gdrm_dist
   import gdrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  pair_type             pair_in,
   input  coord_type            jet_c,
   input  coord_type            parton_c,
   input  logic [DIST_BITS-1:0] max_dr,
   output logic                 sweep_done,
   output logic                 have,
   output logic [JIDX_BITS-1:0] best_jet,
   output logic [PIDX_BITS-1:0] best_parton,
   output logic [DIST_BITS-1:0] best_dist
);
   pair_type p1_ff, p2_ff;
   pair_type p1_in;
   logic signed [DETA_BITS-1:0] deta_ff, deta_in;
   logic signed [DPHI_BITS-1:0] dphi_ff, dphi_in;
   logic [2*DETA_BITS-1:0] eta2_ff;
   logic [2*DPHI_BITS-1:0] phi2_ff;
   logic signed [DPHI_BITS-1:0] dp_raw;
   logic [DPHI_BITS-1:0] dp_abs;
   logic [2*DETA_BITS:0] sum;
   logic have_ff;
   logic [JIDX_BITS-1:0] bj_ff;
   logic [PIDX_BITS-1:0] bp_ff;
   logic [DIST_BITS-1:0] bd_ff;
   logic done_ff;

   assign p1_in = pair_in;

   // Stage 1: differences with phi wrap (memory data arrives with pair_in);
   // the wrapped phi difference goes negative for out-of-range phi inputs
   always_comb begin
      deta_in = DETA_BITS'(jet_c.eta) - DETA_BITS'(parton_c.eta);
      dp_raw  = DPHI_BITS'(jet_c.phi) - DPHI_BITS'(parton_c.phi);
      dp_abs  = dp_raw[DPHI_BITS-1] ? DPHI_BITS'(-dp_raw) : dp_raw;
      dphi_in = (dp_abs > PI_Q) ? TWO_PI_Q - dp_abs : dp_abs;
   end

   always_ff @(posedge clock) begin
      deta_ff <= deta_in;
      dphi_ff <= dphi_in;
      eta2_ff <= (2*DETA_BITS)'(deta_ff * deta_ff);
      phi2_ff <= (2*DPHI_BITS)'(dphi_ff * dphi_ff);
   end

   assign sum = (2*DETA_BITS+1)'(eta2_ff) + (2*DETA_BITS+1)'(phi2_ff);

   // Advance control with the data; keep minimum, lowest index wins ties
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
         p2_ff <= '0;
         have_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         p1_ff <= p1_in;
         p2_ff <= p1_ff;
         done_ff <= p2_ff.sweep_end;
         if (p2_ff.valid && sum <= (2*DETA_BITS+1)'(max_dr) &&
             (!have_ff || sum < (2*DETA_BITS+1)'(bd_ff))) begin
            have_ff <= 1'b1;
            bj_ff <= p2_ff.jet;
            bp_ff <= p2_ff.parton;
            bd_ff <= DIST_BITS'(sum);
         end else if (done_ff) begin
            have_ff <= 1'b0;
         end
      end
   end

   assign sweep_done  = done_ff;
   assign have        = have_ff;
   assign best_jet    = bj_ff;
   assign best_parton = bp_ff;
   assign best_dist   = bd_ff;
endmodule

>>> src/greedy_delta_r_matcher.sv
// Top level: greedy delta-R jet/parton matcher.
// Loads are taken while req_stall is low; req_stall stays low while idle with no result waiting.
// A run sweeps all pairs once per match, and a held match is released before the next
// take; up to min(jets,partons)+1 sweeps, then the final beat. Result stalls can hold
// a run while a held match or the final beat waits.
// Reset (synchronous) clears counts, used flags and rsp_valid and restores the CSR
// defaults; the result data fields and the stores are left as they are.
`timescale 1ns / 1ps
module greedy_delta_r_matcher
   import gdrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic signed [15:0]    req_eta,
   input  logic signed [14:0]    req_phi,
   input  logic signed [7:0]     req_parton_id,
   input  logic [15:0]           req_parton_pt,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [2:0]            rsp_jet_index,
   output logic [3:0]            rsp_parton_index,
   output logic [30:0]           rsp_distance_squared,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [30:0]           csr_write_data
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [DIST_BITS-1:0] max_dr_ff;
   logic [15:0] min_pt_ff;
   logic class_ff;
   logic [JIDX_BITS:0] jcnt_ff;
   logic [PIDX_BITS:0] pcnt_ff;
   logic [MAX_JETS-1:0] jused_ff;
   logic [MAX_PARTONS-1:0] pused_ff;
   logic [JIDX_BITS-1:0] ji_ff;
   logic [PIDX_BITS-1:0] pi_ff;
   logic any_ff;
   pair_type pair_ff, pair_in;
   coord_type wdata, jet_c, parton_c;
   logic accept, jet_we, parton_we, keep, cls;
   logic [7:0] aid;
   logic sweep_done, have;
   logic [JIDX_BITS-1:0] best_jet;
   logic [PIDX_BITS-1:0] best_parton;
   logic [DIST_BITS-1:0] best_dist;
   logic last_pair;
   logic take, done_now, found_now, send_pend, emit_fire;
   logic hold_done_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dr_ff <= 31'd1509949;
         min_pt_ff <= 16'd80;
         class_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_DR: max_dr_ff <= csr_write_data;
            CSR_MIN_PT: min_pt_ff <= csr_write_data[15:0];
            CSR_CLASS:  class_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid;
   assign accept = req_valid && !req_stall;
   assign aid = req_parton_id[7] ? 8'(-req_parton_id) : req_parton_id;
   assign cls = class_ff ? (aid == GLUON_ID) : (aid < QUARK_ID_LIMIT);
   assign keep = (req_parton_id != 8'sd0) && (req_parton_pt > min_pt_ff) && cls;
   assign jet_we = accept && req_command == CMD_LOAD_JET &&
                   jcnt_ff < (JIDX_BITS+1)'(MAX_JETS);
   assign parton_we = accept && req_command == CMD_LOAD_PARTON && keep &&
                      pcnt_ff < (PIDX_BITS+1)'(MAX_PARTONS);
   assign wdata.eta = req_eta;
   assign wdata.phi = req_phi;

   gdrm_store u_store (
      .clock(clock), .jet_we(jet_we), .jet_waddr(jcnt_ff[JIDX_BITS-1:0]),
      .parton_we(parton_we), .parton_waddr(pcnt_ff[PIDX_BITS-1:0]),
      .wdata(wdata), .jet_raddr(ji_ff), .parton_raddr(pi_ff),
      .jet_rdata(jet_c), .parton_rdata(parton_c)
   );

   gdrm_dist u_dist (
      .clock(clock), .reset(reset), .pair_in(pair_ff), .jet_c(jet_c),
      .parton_c(parton_c), .max_dr(max_dr_ff), .sweep_done(sweep_done),
      .have(have), .best_jet(best_jet), .best_parton(best_parton),
      .best_dist(best_dist)
   );

   assign last_pair = ({1'b0, ji_ff} == jcnt_ff - 1'b1) &&
                      ({1'b0, pi_ff} == pcnt_ff - 1'b1);

   // Issue one pair address per cycle; pair control lines up with read data
   always_comb begin
      pair_in = '0;
      if (state_ff == ST_SWEEP) begin
         pair_in.valid = !jused_ff[ji_ff] && !pused_ff[pi_ff];
         pair_in.jet = ji_ff;
         pair_in.parton = pi_ff;
         pair_in.sweep_end = last_pair;
      end
   end

   // Sweep outcome, held while the output side is busy; a match waits in the
   // output register until the next sweep tells whether it is the last one
   assign done_now  = sweep_done || hold_done_ff;
   assign found_now = (sweep_done && have) || hold_done_ff;
   assign send_pend = state_ff == ST_WAIT && found_now && any_ff && !rsp_valid;
   assign take = state_ff == ST_WAIT && found_now && !any_ff && !(rsp_valid && rsp_stall);
   assign emit_fire = state_ff == ST_EMIT && (!rsp_valid || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && req_command == CMD_RUN) begin
                      state_in = (jcnt_ff == '0 || pcnt_ff == '0) ? ST_EMIT : ST_SWEEP;
                   end
         ST_SWEEP: if (last_pair) state_in = ST_WAIT;
         ST_WAIT:  if (done_now) begin
                      state_in = !found_now ? ST_EMIT : (take ? ST_SWEEP : ST_WAIT);
                   end
         ST_EMIT:  if (emit_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         jcnt_ff <= '0;
         pcnt_ff <= '0;
         jused_ff <= '0;
         pused_ff <= '0;
         ji_ff <= '0;
         pi_ff <= '0;
         any_ff <= 1'b0;
         pair_ff <= '0;
         rsp_valid <= 1'b0;
         hold_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pair_ff <= pair_in;
         // Hold the finished sweep while the match cannot be taken
         hold_done_ff <= state_ff == ST_WAIT && found_now && !take;
         if (jet_we) jcnt_ff <= jcnt_ff + 1'b1;
         if (parton_we) pcnt_ff <= pcnt_ff + 1'b1;
         if (send_pend || emit_fire) begin
            rsp_valid <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         // Walk the pair grid
         if (state_ff == ST_SWEEP) begin
            if ({1'b0, pi_ff} == pcnt_ff - 1'b1) begin
               pi_ff <= '0;
               ji_ff <= ({1'b0, ji_ff} == jcnt_ff - 1'b1) ? '0 : ji_ff + 1'b1;
            end else begin
               pi_ff <= pi_ff + 1'b1;
            end
         end
         // Capture a match and mark the pair used
         if (take) begin
            jused_ff[best_jet] <= 1'b1;
            pused_ff[best_parton] <= 1'b1;
            any_ff <= 1'b1;
            rsp_found <= 1'b1;
            rsp_jet_index <= best_jet;
            rsp_parton_index <= best_parton;
            rsp_distance_squared <= best_dist;
            rsp_last <= 1'b0;
         end
         // Release the held match as a middle beat
         if (send_pend) begin
            any_ff <= 1'b0;
         end
         // Final beat: the held match, or the end marker
         if (emit_fire) begin
            rsp_found <= any_ff ? rsp_found : 1'b0;
            rsp_last <= 1'b1;
            if (!any_ff) begin
               rsp_jet_index <= '0;
               rsp_parton_index <= '0;
               rsp_distance_squared <= '0;
            end
            jcnt_ff <= '0;
            pcnt_ff <= '0;
            jused_ff <= '0;
            pused_ff <= '0;
            any_ff <= 1'b0;
         end
      end
   end
endmodule

>>> src/gdrm_checker.sv
// Port-level checker for the matcher, bound to the top level.
`timescale 1ns / 1ps
module gdrm_checker
   import gdrm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [2:0]  rsp_jet_index,
   input logic [3:0]  rsp_parton_index,
   input logic [30:0] rsp_distance_squared,
   input logic        rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance_squared))
      else $error("stalled result beat changed");
   a_empty_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_distance_squared == 31'd0 &&
      rsp_jet_index == 3'd0 && rsp_parton_index == 4'd0)
      else $error("no-match beat malformed");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_RUN |=> req_stall)
      else $error("input taken right after a run beat");
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");
endmodule

bind greedy_delta_r_matcher gdrm_checker u_gdrm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_command(req_command), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_found(rsp_found), .rsp_jet_index(rsp_jet_index),
   .rsp_parton_index(rsp_parton_index),
   .rsp_distance_squared(rsp_distance_squared), .rsp_last(rsp_last)
);
